[sv/assert_macros.svh]
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define SFR_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that also holds during reset
`define SFR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/sfr_pkg.sv]
// types and constants of the stream find and replace unit
package sfr_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned CFG_LEN_W  = 5;
  localparam int unsigned OCC_W      = 17;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = 2;
  localparam int unsigned CMDQ_CNT_W = 3;

  localparam logic [CNT_W-1:0] COUNT_SAT = 16'hFFFF;
  localparam logic [OCC_W-1:0] START_RST = 17'd1;
  localparam logic [OCC_W-1:0] LIMIT_RST = 17'h1FFFF;  // minus one

  typedef enum logic [2:0] {
    REG_PAT_LO,
    REG_PAT_HI,
    REG_PAT_LEN,
    REG_REP_LO,
    REG_REP_HI,
    REG_REP_LEN,
    REG_START,
    REG_LIMIT
  } reg_idx_e;

  typedef struct packed {
    logic [127:0]           pattern;
    logic [CFG_LEN_W-1:0]   pat_len;
    logic [127:0]           repl;
    logic [CFG_LEN_W-1:0]   rep_len;
    logic [OCC_W-1:0]       start;
    logic [OCC_W-1:0]       limit;
  } cfg_t;

  typedef struct packed {
    logic rep;
    logic last;
  } cmd_flags_t;

endpackage

[sv/sfr_cfg.sv]
// register file behind the apb-style configuration port
module sfr_cfg
  import sfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              cfg_clear_o
);

  logic [63:0]          pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [CFG_LEN_W-1:0] pat_len_q, rep_len_q;
  logic [OCC_W-1:0]     start_q, limit_q;
  logic                 wr_en;
  reg_idx_e             idx;

  assign pready      = 1'b1;
  assign idx         = reg_idx_e'(paddr[5:3]);
  assign wr_en       = psel && penable && pwrite && pready;
  assign cfg_clear_o = wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      rep_len_q <= '0;
      start_q   <= START_RST;
      limit_q   <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAT_LO:  pat_lo_q  <= pwdata;
        REG_PAT_HI:  pat_hi_q  <= pwdata;
        REG_PAT_LEN: pat_len_q <= pwdata[CFG_LEN_W-1:0];
        REG_REP_LO:  rep_lo_q  <= pwdata;
        REG_REP_HI:  rep_hi_q  <= pwdata;
        REG_REP_LEN: rep_len_q <= pwdata[CFG_LEN_W-1:0];
        REG_START:   start_q   <= pwdata[OCC_W-1:0];
        REG_LIMIT:   limit_q   <= pwdata[OCC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAT_LO:  prdata = pat_lo_q;
      REG_PAT_HI:  prdata = pat_hi_q;
      REG_PAT_LEN: prdata = {{(DATA_W-CFG_LEN_W){1'b0}}, pat_len_q};
      REG_REP_LO:  prdata = rep_lo_q;
      REG_REP_HI:  prdata = rep_hi_q;
      REG_REP_LEN: prdata = {{(DATA_W-CFG_LEN_W){1'b0}}, rep_len_q};
      REG_START:   prdata = {{(DATA_W-OCC_W){start_q[OCC_W-1]}}, start_q};
      REG_LIMIT:   prdata = {{(DATA_W-OCC_W){limit_q[OCC_W-1]}}, limit_q};
    endcase
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.pat_len = pat_len_q;
  assign cfg_o.repl    = {rep_hi_q, rep_lo_q};
  assign cfg_o.rep_len = rep_len_q;
  assign cfg_o.start   = start_q;
  assign cfg_o.limit   = limit_q;

endmodule

[sv/sfr_front.sv]
// front end: match window, parallel prefix compare and occurrence counting
module sfr_front
  import sfr_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfg_t                             cfg_i,
  input  logic                             cfg_clear_i,
  input  logic                             item_accept_i,
  input  logic [7:0]                       text_byte_i,
  input  logic                             text_last_i,
  output logic                             cmd_push_o,
  output logic [PATTERN_MAX*8-1:0]         cmd_lits_o,
  output logic [$clog2(PATTERN_MAX+1)-1:0] cmd_cnt_o,
  output cmd_flags_t                       cmd_flags_o
);

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);

  logic [7:0]         win_q     [PATTERN_MAX];
  logic [7:0]         w         [PATTERN_MAX];
  logic [7:0]         win_shift [PATTERN_MAX];
  logic [PATTERN_MAX:0] ok;
  logic [FILL_W-1:0]  fill_q, fill_d, nf, shift, rem, plen, cnt;
  logic [CNT_W-1:0]   occ_q, occ_d, done_q, done_d, occ_inc, done_inc;
  logic               suppress, start_pos, limit_ok, active, is_match, do_rep, rep;

  assign plen = (cfg_i.pat_len > CFG_LEN_W'(PATTERN_MAX)) ? FILL_W'(PATTERN_MAX)
                                                          : cfg_i.pat_len[FILL_W-1:0];

  // window with the new byte appended, then smallest shift that leaves a prefix
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      w[j] = (FILL_W'(j) == fill_q) ? text_byte_i : win_q[j];
    end
    nf = fill_q + 1'b1;
    for (int k = 0; k <= PATTERN_MAX; k++) begin
      ok[k] = (k <= int'(nf));
      for (int i = 0; i < int'(PATTERN_MAX) - k; i++) begin
        if (((k + i) < int'(nf)) && (w[k+i] != cfg_i.pattern[8*i +: 8])) begin
          ok[k] = 1'b0;
        end
      end
    end
    shift = nf;
    for (int k = PATTERN_MAX; k >= 0; k--) begin
      if (ok[k]) begin
        shift = FILL_W'(k);
      end
    end
    rem = nf - shift;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      win_shift[j] = w[j];
    end
    for (int k = 1; k < PATTERN_MAX; k++) begin
      if (shift == FILL_W'(k)) begin
        for (int j = 0; j < int'(PATTERN_MAX) - k; j++) begin
          win_shift[j] = w[j+k];
        end
      end
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      cmd_lits_o[8*j +: 8] = w[j];
    end
  end

  assign suppress  = (cfg_i.start == '0) || (cfg_i.limit == '0);
  assign start_pos = !cfg_i.start[OCC_W-1] && (cfg_i.start != '0);
  assign limit_ok  = cfg_i.limit[OCC_W-1] || (done_q < cfg_i.limit[CNT_W-1:0]);
  assign active    = (plen != '0) && start_pos && limit_ok;
  assign occ_inc   = (occ_q == COUNT_SAT) ? occ_q : occ_q + 1'b1;
  assign done_inc  = (done_q == COUNT_SAT) ? done_q : done_q + 1'b1;
  assign is_match  = active && (rem == plen);
  assign do_rep    = is_match && ({1'b0, occ_inc} >= cfg_i.start);

  always_comb begin
    fill_d = fill_q;
    occ_d  = occ_q;
    done_d = done_q;
    cnt    = '0;
    rep    = 1'b0;
    if (item_accept_i) begin
      priority if (suppress) begin
        cnt = '0;
      end else if (!active) begin
        cnt    = nf;
        fill_d = '0;
      end else if (is_match) begin
        occ_d  = occ_inc;
        fill_d = '0;
        if (do_rep) begin
          rep    = 1'b1;
          done_d = done_inc;
        end else begin
          cnt = nf;
        end
      end else begin
        fill_d = rem;
        cnt    = text_last_i ? nf : shift;
      end
      if (text_last_i) begin
        fill_d = '0;
        occ_d  = '0;
        done_d = '0;
      end
    end
    if (cfg_clear_i) begin
      fill_d = '0;
      occ_d  = '0;
      done_d = '0;
    end
  end

  assign cmd_cnt_o        = cnt;
  assign cmd_flags_o.rep  = rep;
  assign cmd_flags_o.last = text_last_i;
  assign cmd_push_o       = item_accept_i &&
                            ((cnt != '0) || (rep && (cfg_i.rep_len != '0)) || text_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      occ_q  <= '0;
      done_q <= '0;
    end else begin
      fill_q <= fill_d;
      occ_q  <= occ_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_accept_i) begin
      win_q <= win_shift;
    end
  end

endmodule

[sv/sfr_cmdq.sv]
// short command queue between front end and back end
module sfr_cmdq
  import sfr_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  logic [WIDTH-1:0]      mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[sv/sfr_back.sv]
// back end: plays out literal and replacement bytes into the result register
module sfr_back
  import sfr_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned REPLACE_MAX = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfg_t                             cfg_i,
  input  logic                             head_valid_i,
  input  logic [PATTERN_MAX*8-1:0]         head_lits_i,
  input  logic [$clog2(PATTERN_MAX+1)-1:0] head_cnt_i,
  input  cmd_flags_t                       head_flags_i,
  output logic                             deq_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [7:0]                       out_byte_o,
  output logic                             byte_valid_o,
  output logic                             out_last_o
);

  localparam int unsigned POS_W = $clog2(PATTERN_MAX + REPLACE_MAX + 1);

  logic [POS_W-1:0] pos_q, rlen, total, cnt_ext, rep_idx;
  logic             out_valid_q, advance, final_elem;
  logic [7:0]       lit_sel, rep_sel, byte_d;
  logic             bvalid_d;

  always_comb begin
    rlen = (cfg_i.rep_len > CFG_LEN_W'(REPLACE_MAX)) ? POS_W'(REPLACE_MAX)
                                                     : POS_W'(cfg_i.rep_len);
    cnt_ext    = POS_W'(head_cnt_i);
    total      = cnt_ext + (head_flags_i.rep ? rlen : '0);
    final_elem = (total == '0) || (pos_q == total - 1'b1);
    advance    = head_valid_i && (!out_valid_q || pop_i);
    deq_o      = advance && final_elem;
    rep_idx    = pos_q - cnt_ext;
    lit_sel    = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (pos_q == POS_W'(i)) begin
        lit_sel = head_lits_i[8*i +: 8];
      end
    end
    rep_sel = '0;
    for (int i = 0; i < REPLACE_MAX; i++) begin
      if (rep_idx == POS_W'(i)) begin
        rep_sel = cfg_i.repl[8*i +: 8];
      end
    end
    // an end-only command gives the bare marker
    bvalid_d = (total != '0);
    byte_d   = !bvalid_d ? 8'h00 : ((pos_q < cnt_ext) ? lit_sel : rep_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      pos_q       <= final_elem ? '0 : pos_q + 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_o   <= byte_d;
      byte_valid_o <= bvalid_d;
      out_last_o   <= head_flags_i.last && final_elem;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

[sv/stream_find_replace_unit.sv]
// top level of the stream find and replace unit
// Streams text one byte per item and returns the text with leftmost
// non-overlapping occurrences of the configured pattern (up to PATTERN_MAX
// bytes) replaced by the configured replacement (up to REPLACE_MAX bytes),
// starting at occurrence start_occurrence and stopping after replace_limit
// replacements. The front end takes one item per clock while the command queue
// is not full: it appends the byte to a match window, compares every shift of
// the window against the pattern in parallel in that same cycle, and hands a
// command (bytes released, replacement flag, end flag) to a four-entry command
// queue. The back end drains one result per clock into the output register
// while the receiver pops or the register is empty. An item that yields nothing
// pushes no command, and the last item of a text with no byte left yields one
// bare end marker. While the back end plays out a replacement or a window flush,
// the queue keeps taking items until it holds four commands. Any configuration
// write drops the text in progress (window and occurrence counters); write only
// while the unit is idle.
module stream_find_replace_unit
  import sfr_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned REPLACE_MAX = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // text items in
  input  logic              push,
  output logic              full,
  input  logic [7:0]        text_byte_i,
  input  logic              text_last_i,
  // result items out
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              out_last_o
);

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CMD_W  = PATTERN_MAX * 8 + FILL_W + $bits(cmd_flags_t);

  cfg_t                     cfg;
  logic                     cfg_clear;
  logic                     item_accept;
  // command from the front end
  logic                     cmd_push;
  logic [PATTERN_MAX*8-1:0] cmd_lits;
  logic [FILL_W-1:0]        cmd_cnt;
  cmd_flags_t               cmd_flags;
  // command at the head of the queue
  logic                     head_valid;
  logic [CMD_W-1:0]         head_data;
  logic [PATTERN_MAX*8-1:0] head_lits;
  logic [FILL_W-1:0]        head_cnt;
  cmd_flags_t               head_flags;
  logic                     deq;

  // the queue's full flag alone gates input, so results can back up freely
  assign item_accept = push && !full;

  sfr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .cfg_clear_o (cfg_clear)
  );

  sfr_front #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cfg_clear_i   (cfg_clear),
    .item_accept_i (item_accept),
    .text_byte_i   (text_byte_i),
    .text_last_i   (text_last_i),
    .cmd_push_o    (cmd_push),
    .cmd_lits_o    (cmd_lits),
    .cmd_cnt_o     (cmd_cnt),
    .cmd_flags_o   (cmd_flags)
  );

  sfr_cmdq #(
    .WIDTH (CMD_W)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i ({cmd_lits, cmd_cnt, cmd_flags}),
    .full_o  (full),
    .pop_i   (deq),
    .rdata_o (head_data),
    .valid_o (head_valid)
  );

  assign {head_lits, head_cnt, head_flags} = head_data;

  sfr_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_lits_i  (head_lits),
    .head_cnt_i   (head_cnt),
    .head_flags_i (head_flags),
    .deq_o        (deq),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .out_last_o   (out_last_o)
  );

endmodule

[sv/sfr_checker.sv]
// port-level checks of the stream find and replace unit, bound to the top level
`include "assert_macros.svh"

module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       out_last_o
);

  `SFR_ASSERT_RST(a_empty_in_reset, !rst_ni |-> empty, "result queue not empty in reset")
  `SFR_ASSERT_CLK(a_hold_stalled, (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(byte_valid_o) && $stable(out_last_o)), "stalled result changed")
  `SFR_ASSERT_CLK(a_marker_is_last, (!empty && !byte_valid_o) |-> out_last_o, "bare marker without last")
  `SFR_ASSERT_CLK(a_marker_zero, (!empty && !byte_valid_o) |-> (out_byte_o == 8'h00), "bare marker with nonzero byte")

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (.*);

[sim/sfr_result_checker.sv]
// result checker for the stream find and replace unit: predicts and compares output items
`timescale 1ns / 100ps

module sfr_result_checker
  import sfr_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned REPLACE_MAX = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [7:0]        text_byte_i,
  input  logic              text_last_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic [7:0]        out_byte_i,
  input  logic              byte_valid_i,
  input  logic              out_last_i,
  output int unsigned       err_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } text_result_t;

  text_result_t expected_text[$];

  // register copy
  logic [127:0] pat_bytes;
  logic [127:0] rep_bytes;
  int           pat_len_cfg;
  int           rep_len_cfg;
  int           start_occ;
  int           rep_limit;

  // per-text state
  logic [7:0]   window_bytes[PATTERN_MAX];
  int           win_fill;
  int           occ_seen;
  int           reps_done;

  function automatic logic [7:0] pattern_byte(int i);
    return pat_bytes[i*8 +: 8];
  endfunction

  task automatic emit_byte(input logic [7:0] value);
    text_result_t res;
    res.data  = value;
    res.valid = 1'b1;
    res.last  = 1'b0;
    expected_text.push_back(res);
  endtask

  task automatic release_oldest();
    emit_byte(window_bytes[0]);
    for (int i = 1; i < win_fill && i < PATTERN_MAX; i++)
      window_bytes[i-1] = window_bytes[i];
    win_fill--;
  endtask

  function automatic bit window_is_prefix(int plen);
    if (win_fill > plen)
      return 1'b0;
    for (int i = 0; i < win_fill; i++)
      if (window_bytes[i] != pattern_byte(i))
        return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_text();
    win_fill  = 0;
    occ_seen  = 0;
    reps_done = 0;
  endtask

  task automatic apply_register_write(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_PAT_LO:  pat_bytes[63:0]   = value;
      REG_PAT_HI:  pat_bytes[127:64] = value;
      REG_PAT_LEN: pat_len_cfg       = int'(value[CFG_LEN_W-1:0]);
      REG_REP_LO:  rep_bytes[63:0]   = value;
      REG_REP_HI:  rep_bytes[127:64] = value;
      REG_REP_LEN: rep_len_cfg       = int'(value[CFG_LEN_W-1:0]);
      REG_START:   start_occ         = int'($signed(value[OCC_W-1:0]));
      REG_LIMIT:   rep_limit         = int'($signed(value[OCC_W-1:0]));
      default: ;
    endcase
    clear_text();
  endtask

  // expected output items caused by one text item
  task automatic predict_replaced_text(input logic [7:0] value, input logic is_last);
    int           base;
    int           plen;
    int           rlen;
    bit           active;
    text_result_t tail;
    base = expected_text.size();
    if (start_occ != 0 && rep_limit != 0) begin
      plen   = (pat_len_cfg > PATTERN_MAX) ? PATTERN_MAX : pat_len_cfg;
      rlen   = (rep_len_cfg > REPLACE_MAX) ? REPLACE_MAX : rep_len_cfg;
      active = plen > 0 && start_occ > 0 && (rep_limit < 0 || reps_done < rep_limit);
      if (!active) begin
        while (win_fill > 0)
          release_oldest();
        emit_byte(value);
      end else begin
        if (win_fill >= plen)
          while (win_fill > 0)
            release_oldest();
        window_bytes[win_fill] = value;
        win_fill++;
        while (win_fill > 0 && !window_is_prefix(plen))
          release_oldest();
        if (win_fill == plen) begin
          if (occ_seen < int'(COUNT_SAT))
            occ_seen++;
          if (occ_seen >= start_occ) begin
            for (int i = 0; i < rlen; i++)
              emit_byte(rep_bytes[i*8 +: 8]);
            if (reps_done < int'(COUNT_SAT))
              reps_done++;
          end else begin
            for (int i = 0; i < plen; i++)
              emit_byte(pattern_byte(i));
          end
          win_fill = 0;
        end
      end
      if (is_last)
        while (win_fill > 0)
          release_oldest();
    end
    if (is_last) begin
      if (expected_text.size() > base) begin
        tail      = expected_text.pop_back();
        tail.last = 1'b1;
        expected_text.push_back(tail);
      end else begin
        tail.data  = 8'h00;
        tail.valid = 1'b0;
        tail.last  = 1'b1;
        expected_text.push_back(tail);
      end
      clear_text();
    end
  endtask

  task automatic check_result();
    text_result_t exp;
    if (expected_text.size() == 0) begin
      err_count_o++;
      $display("%0t: unexpected item byte=%02h valid=%b last=%b", $time,
               out_byte_i, byte_valid_i, out_last_i);
    end else begin
      exp = expected_text.pop_front();
      checked_o++;
      if (out_byte_i !== exp.data || byte_valid_i !== exp.valid || out_last_i !== exp.last) begin
        err_count_o++;
        $display("%0t: mismatch expected byte=%02h valid=%b last=%b got byte=%02h valid=%b last=%b",
                 $time, exp.data, exp.valid, exp.last, out_byte_i, byte_valid_i, out_last_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_text.delete();
      pat_bytes   = '0;
      rep_bytes   = '0;
      pat_len_cfg = 0;
      rep_len_cfg = 0;
      start_occ   = int'($signed(START_RST));
      rep_limit   = int'($signed(LIMIT_RST));
      clear_text();
      err_count_o = 0;
      checked_o   = 0;
      pending_o   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i)
        apply_register_write(reg_idx_e'(paddr_i[ADDR_W-1:3]), pwdata_i);
      if (pop_i && !empty_i)
        check_result();
      if (push_i && !full_i)
        predict_replaced_text(text_byte_i, text_last_i);
      pending_o = expected_text.size();
    end
  end

endmodule

[sim/tb.sv]
// testbench top for the stream find and replace unit: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb;
  import sfr_pkg::*;

  localparam int unsigned PAT_MAX       = 16;
  localparam int unsigned REP_MAX       = 16;
  localparam int unsigned RANDOM_ITEMS  = 380;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned SETTLE_CYCLES = 24;

  // idling mixes, rotated per phase
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push;
  logic              full;
  logic [7:0]        text_byte_i;
  logic              text_last_i;
  logic              empty;
  logic              pop;
  logic [7:0]        out_byte_o;
  logic              byte_valid_o;
  logic              out_last_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;

  // idling percentages of the current phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // pattern in use, kept to build texts that hit it
  logic [127:0] cur_pat;
  int unsigned  cur_plen;

  int unsigned items_sent;
  int unsigned texts_sent;
  int unsigned settings_written;

  stream_find_replace_unit #(
    .PATTERN_MAX(PAT_MAX),
    .REPLACE_MAX(REP_MAX)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .push        (push),
    .full        (full),
    .text_byte_i (text_byte_i),
    .text_last_i (text_last_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .out_last_o  (out_last_o)
  );

  // watches config port and both item channels
  sfr_result_checker #(
    .PATTERN_MAX(PAT_MAX),
    .REPLACE_MAX(REP_MAX)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .push_i      (push),
    .full_i      (full),
    .text_byte_i (text_byte_i),
    .text_last_i (text_last_i),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_byte_i  (out_byte_o),
    .byte_valid_i(byte_valid_o),
    .out_last_i  (out_last_o),
    .err_count_o (mismatch_count),
    .pending_o   (pending_count),
    .checked_o   (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: pop decided fresh every cycle
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop in case the unit hangs
  initial begin
    #3000000;
    $display("timeout with %0d items still expected", pending_count);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 76;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 76;
      end
      default: begin
        send_idle_pct  = 29;
        recv_stall_pct = 29;
      end
    endcase
  endtask

  // setup cycle, access cycle, register taken at the edge after the access cycle starts
  task automatic apb_write(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // every register written; also drops any text in progress
  task automatic write_settings(input logic [127:0] pat, input int plen,
                                input logic [127:0] rep, input int rlen,
                                input int start, input int limit);
    apb_write(REG_PAT_LO,  pat[63:0]);
    apb_write(REG_PAT_HI,  pat[127:64]);
    apb_write(REG_PAT_LEN, {59'd0, plen[4:0]});
    apb_write(REG_REP_LO,  rep[63:0]);
    apb_write(REG_REP_HI,  rep[127:64]);
    apb_write(REG_REP_LEN, {59'd0, rlen[4:0]});
    apb_write(REG_START,   {47'd0, start[16:0]});
    apb_write(REG_LIMIT,   {47'd0, limit[16:0]});
    cur_pat  = pat;
    cur_plen = (plen > PAT_MAX) ? PAT_MAX : plen;
    settings_written++;
  endtask

  // push stays high across back-to-back items; this task lowers it only for a gap
  task automatic send_text_item(input logic [7:0] value, input logic is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    push        <= 1'b1;
    text_byte_i <= value;
    text_last_i <= is_last;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // drain: nothing expected, then let the unit settle before any register write
  task automatic finish_phase();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_settings();
    logic [127:0] pat;
    logic [127:0] rep;
    int           plen;
    int           rlen;
    int           start;
    int           limit;
    pat = {$urandom(), $urandom(), $urandom(), $urandom()};
    rep = {$urandom(), $urandom(), $urandom(), $urandom()};
    // mostly a two-letter alphabet so partial matches and restarts are common
    if ($urandom_range(9) < 7)
      for (int i = 0; i < 16; i++)
        pat[i*8 +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
    case ($urandom_range(9))
      0:          plen = 0;
      1, 2, 3, 4: plen = $urandom_range(1, 3);
      5, 6:       plen = $urandom_range(4, 8);
      7:          plen = $urandom_range(9, 15);
      8:          plen = 16;
      default:    plen = $urandom_range(17, 31);
    endcase
    case ($urandom_range(9))
      0:                rlen = 0;
      1, 2, 3, 4, 5:    rlen = $urandom_range(1, 3);
      6, 7:             rlen = $urandom_range(4, 15);
      8:                rlen = 16;
      default:          rlen = $urandom_range(17, 31);
    endcase
    case ($urandom_range(11))
      6:       start = 2;
      7:       start = 3;
      8:       start = 0;
      9:       start = -1;
      10:      start = 65535;
      11:      start = int'($urandom_range(65536, 131071)) - 131072;
      default: start = 1;
    endcase
    case ($urandom_range(11))
      6:       limit = 1;
      7:       limit = 2;
      8:       limit = 0;
      9:       limit = 3;
      10:      limit = 65535;
      11:      limit = $urandom_range(1) ? int'($urandom_range(65536, 131071)) - 131072
                                         : int'($urandom_range(1, 65535));
      default: limit = -1;
    endcase
    write_settings(pat, plen, rep, rlen, start, limit);
  endtask

  // text built from whole patterns, broken prefixes and noise bytes
  task automatic send_random_text(output int unsigned count);
    logic [7:0]  text_q[$];
    int unsigned target;
    int unsigned k;
    int unsigned cut;
    target = $urandom_range(1, 24);
    while (text_q.size() < target) begin
      k = $urandom_range(9);
      if (k < 4 && cur_plen > 0) begin
        for (int i = 0; i < cur_plen; i++)
          text_q.push_back(cur_pat[i*8 +: 8]);
      end else if (k < 6 && cur_plen > 1) begin
        cut = $urandom_range(1, cur_plen - 1);
        for (int i = 0; i < cut; i++)
          text_q.push_back(cur_pat[i*8 +: 8]);
      end else if (k < 8) begin
        text_q.push_back($urandom_range(1) ? 8'h61 : 8'h62);
      end else begin
        text_q.push_back(8'($urandom_range(255)));
      end
    end
    foreach (text_q[i])
      send_text_item(text_q[i], i == text_q.size() - 1);
    texts_sent++;
    count = text_q.size();
  endtask

  initial begin
    logic [127:0] pat;
    logic [127:0] rep;
    int unsigned  phase;
    int unsigned  random_items;
    int unsigned  phase_items;
    int unsigned  n;

    rst_ni         <= 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    push           = 1'b0;
    text_byte_i    = 8'h00;
    text_last_i    = 1'b0;
    pop            = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_pat        = '0;
    cur_plen       = 0;
    items_sent       = 0;
    texts_sent       = 0;
    settings_written = 0;
    random_items     = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: empty pattern, text passes unchanged
    set_idling(IDLE_NONE);
    send_text_item(8'h00, 1'b0);
    send_text_item(8'hFF, 1'b1);
    texts_sent++;
    finish_phase();

    // zero start: only the bare end marker comes out
    pat = {$urandom(), $urandom(), $urandom(), $urandom()};
    pat[7:0] = 8'h61;
    rep = {$urandom(), $urandom(), $urandom(), $urandom()};
    write_settings(pat, 1, rep, 1, 0, -1);
    set_idling(IDLE_SENDER);
    send_text_item(8'h41, 1'b1);
    texts_sent++;
    finish_phase();

    // zero limit: same, even on a matching byte
    write_settings(pat, 1, rep, 1, 1, 0);
    set_idling(IDLE_RECEIVER);
    send_text_item(8'h61, 1'b1);
    texts_sent++;
    finish_phase();

    // negative start: matching byte passes unchanged
    write_settings(pat, 1, rep, 1, -1, -1);
    set_idling(IDLE_BOTH);
    send_text_item(8'h61, 1'b1);
    texts_sent++;
    finish_phase();

    // empty replacement deletes the match, largest limit
    write_settings(pat, 1, rep, 0, 1, 65535);
    set_idling(IDLE_NONE);
    send_text_item(8'h61, 1'b0);
    send_text_item(8'h63, 1'b1);
    texts_sent++;
    finish_phase();

    // "ab" -> "XYZ" from the second occurrence, one replacement, then limit reached;
    // trailing byte passes unchanged at the end of text once the limit is reached
    pat[15:0] = 16'h6261;
    rep[23:0] = 24'h5A5958;
    write_settings(pat, 2, rep, 3, 2, 1);
    set_idling(IDLE_SENDER);
    send_text_item(8'h61, 1'b0);
    send_text_item(8'h62, 1'b0);
    send_text_item(8'h61, 1'b0);
    send_text_item(8'h62, 1'b0);
    send_text_item(8'h61, 1'b1);
    texts_sent++;
    // a held byte left in the window, abandoned by the next register write
    send_text_item(8'h61, 1'b0);
    finish_phase();

    // lengths above the maximum saturate: full 16-byte match, 16-byte replacement
    pat = {$urandom(), $urandom(), $urandom(), $urandom()};
    rep = {$urandom(), $urandom(), $urandom(), $urandom()};
    write_settings(pat, 31, rep, 31, 1, -1);
    set_idling(IDLE_RECEIVER);
    for (int i = 0; i < 16; i++)
      send_text_item(pat[i*8 +: 8], i == 15);
    texts_sent++;
    finish_phase();

    // random settings and texts, idling mix rotated per phase
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick_settings();
      set_idling(idle_mode_e'(phase % 4));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
        send_random_text(n);
        phase_items += n;
        random_items += n;
      end
      finish_phase();
      phase++;
    end

    $display("covered %0d text items in %0d texts under %0d register settings", items_sent,
             texts_sent, settings_written);
    $display("compared %0d output items, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
